@@ hdl/buddy_block_allocator_top_assert.svh @@
// Assertion macros for the buddy block allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define BBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("buddy allocator check failed");

// Condition must never be seen outside reset.
`define BBA_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("buddy allocator forbidden condition");

`endif

@@ hdl/bba_pkg.sv @@
// Shared constants and types of the buddy block allocator.
package bba_pkg;
  localparam int POOL_UNITS  = 64;
  localparam int ADDR_W      = 6;
  localparam int ORDER_COUNT = 7;
  localparam int ORD_W       = 3;
  localparam logic [ORD_W-1:0] TOP_ORDER = ORD_W'(ORDER_COUNT - 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] wdata;
  } wr_t;

  typedef struct packed {
    wr_t               bsy;
    wr_t               ord;
    wr_t               nxt;
    wr_t               prv;
    logic [ADDR_W-1:0] ra_bo;
    logic [ADDR_W-1:0] ra_np;
  } store_req_t;

  typedef struct packed {
    logic              busy;
    logic [ORD_W-1:0]  order;
    logic [ADDR_W-1:0] next;
    logic [ADDR_W-1:0] prev;
  } store_rsp_t;
endpackage

@@ hdl/bba_store.sv @@
// Per-unit state memories (busy, order, links) with per-entry valid bits.
module bba_store import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);
  logic              bsy_mem [POOL_UNITS];
  logic [ORD_W-1:0]  ord_mem [POOL_UNITS];
  logic [ADDR_W-1:0] nxt_mem [POOL_UNITS];
  logic [ADDR_W-1:0] prv_mem [POOL_UNITS];
  logic [POOL_UNITS-1:0] bsy_vld_q, ord_vld_q, nxt_vld_q, prv_vld_q;

  logic              bsy_rd_q, bsy_rv_q, ord_rv_q, nxt_rv_q, prv_rv_q;
  logic [ORD_W-1:0]  ord_rd_q;
  logic [ADDR_W-1:0] nxt_rd_q, prv_rd_q, ra_bo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.bsy.we) bsy_mem[req_i.bsy.waddr] <= req_i.bsy.wdata[0];
    if (req_i.ord.we) ord_mem[req_i.ord.waddr] <= req_i.ord.wdata[ORD_W-1:0];
    if (req_i.nxt.we) nxt_mem[req_i.nxt.waddr] <= req_i.nxt.wdata;
    if (req_i.prv.we) prv_mem[req_i.prv.waddr] <= req_i.prv.wdata;
    bsy_rd_q <= bsy_mem[req_i.ra_bo];
    ord_rd_q <= ord_mem[req_i.ra_bo];
    nxt_rd_q <= nxt_mem[req_i.ra_np];
    prv_rd_q <= prv_mem[req_i.ra_np];
    ra_bo_q  <= req_i.ra_bo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsy_vld_q <= '0;
      ord_vld_q <= '0;
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
      bsy_rv_q  <= 1'b0;
      ord_rv_q  <= 1'b0;
      nxt_rv_q  <= 1'b0;
      prv_rv_q  <= 1'b0;
    end else begin
      if (req_i.bsy.we) bsy_vld_q[req_i.bsy.waddr] <= 1'b1;
      if (req_i.ord.we) ord_vld_q[req_i.ord.waddr] <= 1'b1;
      if (req_i.nxt.we) nxt_vld_q[req_i.nxt.waddr] <= 1'b1;
      if (req_i.prv.we) prv_vld_q[req_i.prv.waddr] <= 1'b1;
      bsy_rv_q <= bsy_vld_q[req_i.ra_bo];
      ord_rv_q <= ord_vld_q[req_i.ra_bo];
      nxt_rv_q <= nxt_vld_q[req_i.ra_np];
      prv_rv_q <= prv_vld_q[req_i.ra_np];
    end
  end

  // Unwritten entries read as their reset value: only unit zero holds the top order.
  assign rsp_o.busy  = bsy_rv_q & bsy_rd_q;
  assign rsp_o.order = ord_rv_q ? ord_rd_q :
                       ((ra_bo_q == '0) ? TOP_ORDER : '0);
  assign rsp_o.next  = nxt_rv_q ? nxt_rd_q : '0;
  assign rsp_o.prev  = prv_rv_q ? prv_rd_q : '0;
endmodule

@@ hdl/buddy_block_allocator_top.sv @@
// Buddy block allocator over a 64-unit pool: sequencer, free lists and result register.
// An allocate removes the head of the first fitting list and then splits one order at a time;
// a free merges one order at a time, then pushes the merged block onto its list.
// Throughput: one transfer at a time; the input is taken again the cycle after the result is
// loaded into the output register, and loading waits while the previous result is unread.
// Reset: asynchronous, active low; the pool starts as one free order-six block at unit zero.
module buddy_block_allocator_top import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] request_size, [13:8] block_address, zero pad
  input  logic        s_axis_tuser_i,  // [0] mode: 0 allocate, 1 free
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [1:0] status, [7:2] result_address,
                                       // [10:8] result_order, zero pad
);
  `include "buddy_block_allocator_top_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AFIND = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_RM0   = 4'd3;
  localparam logic [3:0] S_RM1   = 4'd4;
  localparam logic [3:0] S_PUSH0 = 4'd5;
  localparam logic [3:0] S_PUSH1 = 4'd6;
  localparam logic [3:0] S_PUSH2 = 4'd7;
  localparam logic [3:0] S_FR0   = 4'd8;
  localparam logic [3:0] S_FR1   = 4'd9;
  localparam logic [3:0] S_FR2   = 4'd10;
  localparam logic [3:0] S_FR3   = 4'd11;
  localparam logic [3:0] S_FR4   = 4'd12;
  localparam logic [3:0] S_FEND  = 4'd13;
  localparam logic [3:0] S_FDONE = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]        state_q, state_d, ret_q, ret_d;
  logic [ADDR_W-1:0] a_q, a_d, u_q, u_d, p_q, p_d;
  logic [ORD_W-1:0]  k_q, k_d, need_q, need_d, i_q, i_d, ord_q, ord_d;
  logic              fail_q, fail_d;
  logic [ADDR_W-1:0] head_q [ORDER_COUNT];
  logic [ADDR_W-1:0] head_d [ORDER_COUNT];
  logic [ORDER_COUNT-1:0] ne_q, ne_d;
  logic [1:0]        rs_q, rs_d;
  logic [ADDR_W-1:0] ra_q, ra_d;
  logic [ORD_W-1:0]  ro_q, ro_d;
  logic              mv_q, mv_d;
  logic [1:0]        ms_q, ms_d;
  logic [ADDR_W-1:0] ma_q, ma_d;
  logic [ORD_W-1:0]  mo_q, mo_d;

  store_req_t req;
  store_rsp_t rsp;

  logic [7:0]        in_size;
  logic [ORD_W-1:0]  need_c, k_c;
  logic              k_ok;
  logic [ADDR_W-1:0] split_c, buddy_c, lo_c;
  logic [ORD_W-1:0]  ord_clamp;

  bba_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_size = s_axis_tdata_i[7:0];

  // Smallest order whose block covers the request; zero asks for one unit.
  always_comb begin
    need_c = '0;
    for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
      if (in_size <= 8'(1 << i)) need_c = ORD_W'(i);
    end
  end

  // First non-empty list at or above the needed order.
  always_comb begin
    k_c  = '0;
    k_ok = 1'b0;
    for (int i = ORDER_COUNT - 1; i >= 0; i--) begin
      if (ORD_W'(i) >= need_q && ne_q[i]) begin
        k_c  = ORD_W'(i);
        k_ok = 1'b1;
      end
    end
  end

  assign split_c   = a_q + (ADDR_W'(1) << i_q);
  assign buddy_c   = a_q ^ (ADDR_W'(1) << k_q);
  assign lo_c      = (u_q < a_q) ? u_q : a_q;
  assign ord_clamp = (rsp.order > TOP_ORDER) ? TOP_ORDER : rsp.order;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    a_d     = a_q;
    u_d     = u_q;
    p_d     = p_q;
    k_d     = k_q;
    need_d  = need_q;
    i_d     = i_q;
    ord_d   = ord_q;
    fail_d  = fail_q;
    head_d  = head_q;
    ne_d    = ne_q;
    rs_d    = rs_q;
    ra_d    = ra_q;
    ro_d    = ro_q;
    mv_d    = mv_q;
    ms_d    = ms_q;
    ma_d    = ma_q;
    mo_d    = mo_q;
    req       = '0;
    req.ra_bo = a_q;
    req.ra_np = u_q;

    // Drop the result once the sink takes it.
    if (mv_q && m_axis_tready_i) mv_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          a_d = s_axis_tdata_i[13:8];
          if (s_axis_tuser_i) begin
            state_d = S_FR0;
          end else begin
            need_d  = need_c;
            fail_d  = in_size > 8'(POOL_UNITS);
            state_d = S_AFIND;
          end
        end
      end
      S_AFIND: begin
        if (fail_q || !k_ok) begin
          rs_d    = ST_NO_SPACE;
          ra_d    = '0;
          ro_d    = '0;
          state_d = S_OUT;
        end else begin
          k_d     = k_c;
          a_d     = head_q[k_c];
          u_d     = head_q[k_c];
          ord_d   = k_c;
          i_d     = need_q;
          ret_d   = S_SPLIT;
          state_d = S_RM0;
        end
      end
      S_SPLIT: begin
        if (i_q < k_q) begin
          // Hand the upper half back to the list of order i.
          req.ord = '{we: 1'b1, waddr: split_c, wdata: ADDR_W'(i_q)};
          req.bsy = '{we: 1'b1, waddr: split_c, wdata: '0};
          u_d     = split_c;
          ord_d   = i_q;
          i_d     = i_q + 1'b1;
          ret_d   = S_SPLIT;
          state_d = S_PUSH0;
        end else begin
          req.ord = '{we: 1'b1, waddr: a_q, wdata: ADDR_W'(need_q)};
          req.bsy = '{we: 1'b1, waddr: a_q, wdata: ADDR_W'(1)};
          rs_d    = ST_OK;
          ra_d    = a_q;
          ro_d    = need_q;
          state_d = S_OUT;
        end
      end
      S_RM0: begin
        state_d = S_RM1;
      end
      S_RM1: begin
        if (rsp.next == u_q) begin
          ne_d[ord_q] = 1'b0;
        end else begin
          req.nxt = '{we: 1'b1, waddr: rsp.prev, wdata: rsp.next};
          req.prv = '{we: 1'b1, waddr: rsp.next, wdata: rsp.prev};
          head_d[ord_q] = rsp.next;
        end
        state_d = ret_q;
      end
      S_PUSH0: begin
        req.ra_np = head_q[ord_q];
        if (!ne_q[ord_q]) begin
          req.nxt = '{we: 1'b1, waddr: u_q, wdata: u_q};
          req.prv = '{we: 1'b1, waddr: u_q, wdata: u_q};
          ne_d[ord_q]   = 1'b1;
          head_d[ord_q] = u_q;
          state_d       = ret_q;
        end else begin
          state_d = S_PUSH1;
        end
      end
      S_PUSH1: begin
        req.nxt = '{we: 1'b1, waddr: u_q, wdata: head_q[ord_q]};
        req.prv = '{we: 1'b1, waddr: u_q, wdata: rsp.prev};
        p_d     = rsp.prev;
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        req.nxt = '{we: 1'b1, waddr: p_q, wdata: u_q};
        req.prv = '{we: 1'b1, waddr: head_q[ord_q], wdata: u_q};
        head_d[ord_q] = u_q;
        state_d       = ret_q;
      end
      S_FR0: begin
        state_d = S_FR1;
      end
      S_FR1: begin
        if (!rsp.busy) begin
          rs_d    = ST_BAD_FREE;
          ra_d    = '0;
          ro_d    = '0;
          state_d = S_OUT;
        end else begin
          req.bsy = '{we: 1'b1, waddr: a_q, wdata: '0};
          k_d     = ord_clamp;
          state_d = S_FR2;
        end
      end
      S_FR2: begin
        req.ra_bo = buddy_c;
        u_d       = buddy_c;
        state_d   = (k_q < TOP_ORDER) ? S_FR3 : S_FEND;
      end
      S_FR3: begin
        // Merge only with a free buddy of the same order.
        if (rsp.busy || rsp.order != k_q) begin
          state_d = S_FEND;
        end else begin
          ord_d   = k_q;
          ret_d   = S_FR4;
          state_d = S_RM0;
        end
      end
      S_FR4: begin
        a_d     = lo_c;
        k_d     = k_q + 1'b1;
        req.ord = '{we: 1'b1, waddr: lo_c, wdata: ADDR_W'(k_q + 1'b1)};
        state_d = S_FR2;
      end
      S_FEND: begin
        req.ord = '{we: 1'b1, waddr: a_q, wdata: ADDR_W'(k_q)};
        u_d     = a_q;
        ord_d   = k_q;
        ret_d   = S_FDONE;
        state_d = S_PUSH0;
      end
      S_FDONE: begin
        rs_d    = ST_OK;
        ra_d    = a_q;
        ro_d    = k_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free.
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          ms_d    = rs_q;
          ma_d    = ra_q;
          mo_d    = ro_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      ne_q    <= ORDER_COUNT'(1) << (ORDER_COUNT - 1);
      mv_q    <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) head_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ne_q    <= ne_d;
      mv_q    <= mv_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    u_q    <= u_d;
    p_q    <= p_d;
    k_q    <= k_d;
    need_q <= need_d;
    i_q    <= i_d;
    ord_q  <= ord_d;
    fail_q <= fail_d;
    rs_q   <= rs_d;
    ra_q   <= ra_d;
    ro_q   <= ro_d;
    ms_q   <= ms_d;
    ma_q   <= ma_d;
    mo_q   <= mo_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {5'b0, mo_q, ma_q, ms_q};

  logic aligned;
  assign aligned = ((ma_q & ~(ADDR_W'({ADDR_W{1'b1}}) << mo_q)) == '0);

  `BBA_NEVER(a_status_code, mv_q && ms_q != ST_OK && ms_q != ST_NO_SPACE && ms_q != ST_BAD_FREE)
  `BBA_NEVER(a_block_aligned, mv_q && ms_q == ST_OK && !aligned)
  `BBA_ASSERT(a_accept_busy, (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
endmodule
